### design/sha1_pkg.sv
// shared types and constants for the sha-1 digest block
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned ROUNDS = 80;
    localparam int unsigned DIGEST_WORDS = 5;

    // datapath commands from the controller
    typedef struct packed {
        logic       put_byte;   // write a message byte at the fill position
        logic       put_pad;    // write the padding marker at the fill position
        logic       put_zero;   // write a zero byte at the fill position
        logic       put_len;    // write the bit length into words 14 and 15
        logic       start;      // copy chaining words into round words
        logic       round;      // run one round
        logic       finish;     // add round words into chaining words
        logic       shift_out;  // rotate chaining words toward the output
        logic       clear;      // back to the initial state
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;        // fill position in the block
        logic       last_round;
    } t_status;

endpackage

### design/sha1_datapath.sv
// sha-1 datapath: block buffer, round unit, chaining words and length count
module sha1_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_cmd      i_cmd,
    input  logic [7:0]          i_byte,
    output sha1_pkg::t_status   o_status,
    output logic [31:0]         o_head_word
);
    import sha1_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_v [5];
    logic [60:0] r_len;
    logic [6:0]  r_rnd;
    logic [5:0]  r_pos;

    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [31:0] byte_val;
    logic [31:0] sched, w_cur, f, k, t;
    logic [3:0]  ri;
    logic [63:0] bits;

    assign wi = r_pos[5:2];
    assign sh = {~r_pos[1:0], 3'b000};
    assign ri = r_rnd[3:0];
    assign bits = {r_len, 3'b000};

    always_comb begin
        byte_val = '0;
        if (i_cmd.put_byte) begin
            byte_val = {24'h0, i_byte};
        end else if (i_cmd.put_pad) begin
            byte_val = {24'h0, PAD_BYTE};
        end
        sched = r_w[4'(ri - 4'd3)] ^ r_w[4'(ri - 4'd8)] ^ r_w[4'(ri - 4'd14)] ^ r_w[ri];
        sched = {sched[30:0], sched[31]};
        w_cur = (r_rnd < 7'd16) ? r_w[ri] : sched;
        if (r_rnd < 7'd20) begin
            f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k = K2;
        end else begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K3;
        end
        t = {r_v[0][26:0], r_v[0][31:27]} + f + r_v[4] + k + w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte || i_cmd.put_pad || i_cmd.put_zero) begin
            if (r_pos[1:0] == 2'd0) begin
                r_w[wi] <= byte_val << sh;
            end else begin
                r_w[wi] <= r_w[wi] | (byte_val << sh);
            end
        end
        if (i_cmd.put_len) begin
            r_w[14] <= bits[63:32];
            r_w[15] <= bits[31:0];
        end
        if (i_cmd.round && r_rnd >= 7'd16) begin
            r_w[ri] <= sched;
        end
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[0] <= t;
            r_v[1] <= r_v[0];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_h   <= '{H0, H1, H2, H3, H4};
            r_len <= '0;
            r_rnd <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.finish) begin
                for (int j = 0; j < 5; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end else if (i_cmd.shift_out) begin
                r_h <= '{r_h[1], r_h[2], r_h[3], r_h[4], r_h[0]};
            end
            if (i_cmd.put_byte) begin
                r_len <= r_len + 61'd1;
            end
            if (i_cmd.put_byte || i_cmd.put_pad || i_cmd.put_zero) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.round) begin
                r_rnd <= (r_rnd == 7'(ROUNDS - 1)) ? 7'd0 : r_rnd + 7'd1;
            end
        end
    end

    assign o_status.pos = r_pos;
    assign o_status.last_round = (r_rnd == 7'(ROUNDS - 1));
    assign o_head_word = r_h[0];

`ifndef SYNTHESIS
    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.round && o_status.last_round && !i_cmd.clear) |=> (r_rnd == 7'd0))
        else $error("round counter did not wrap");
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_byte && !i_cmd.clear) |=> (r_len == $past(r_len) + 61'd1))
        else $error("length count slip");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.put_byte, i_cmd.put_pad, i_cmd.put_zero, i_cmd.round}))
        else $error("conflicting datapath commands");
`endif

endmodule

### design/sha1_ctrl.sv
// sha-1 controller: input acceptance, padding sequence, rounds and digest output
module sha1_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_has_byte,
    input  logic                i_is_last,
    input  sha1_pkg::t_status   i_status,
    output sha1_pkg::t_cmd      o_cmd,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_FIN, S_PAD, S_ZERO, S_LEN, S_OUT
    } t_state;

    t_state     r_state;
    logic       r_final;
    logic       r_pad_done;
    logic [2:0] r_idx;
    logic       acc;

    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_word_index = r_idx;
    assign o_last_word = (r_idx == 3'(DIGEST_WORDS - 1));

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.put_byte = acc && i_has_byte;
                o_cmd.start = acc && i_has_byte && (i_status.pos == 6'd63);
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            S_PAD: begin
                o_cmd.put_pad = 1'b1;
                o_cmd.start = (i_status.pos == 6'd63);
            end
            S_ZERO: begin
                o_cmd.put_zero = 1'b1;
                o_cmd.start = (i_status.pos == 6'd63);
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                o_cmd.start = 1'b1;
            end
            S_OUT: begin
                o_cmd.shift_out = !i_stall;
                o_cmd.clear = !i_stall && o_last_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_final    <= 1'b0;
            r_pad_done <= 1'b0;
            r_idx      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_final <= i_is_last;
                        if (i_has_byte && i_status.pos == 6'd63) begin
                            r_state <= S_ROUND;
                        end else if (i_is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    if (i_status.last_round) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (r_idx == 3'd7) begin
                        r_state <= S_OUT;
                        r_idx <= '0;
                    end else if (r_pad_done) begin
                        r_state <= S_ZERO;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_idx <= '0;
                    r_pad_done <= 1'b1;
                    if (i_status.pos == 6'd63) begin
                        r_state <= S_ROUND;
                    end else if (i_status.pos == 6'd55) begin
                        r_state <= S_LEN;
                    end else begin
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (i_status.pos == 6'd63) begin
                        r_state <= S_ROUND;
                    end else if (i_status.pos == 6'd55) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_state <= S_ROUND;
                    r_idx <= 3'd7;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (o_last_word) begin
                            r_state <= S_IDLE;
                            r_idx <= '0;
                            r_final <= 1'b0;
                            r_pad_done <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // once the pad byte is in, a further block is zero fill then length
    // (r_idx of 7 is set only by S_LEN and marks the final compression)

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == 3'd0))
        else $error("digest did not start at word 0");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> (r_state == S_IDLE))
        else $error("no return to idle after digest");
`endif

endmodule

### design/sha1_message_digest.sv
// sha-1 digest top level
// Bytes are taken one per cycle while idle. A byte that completes a 64-byte
// block holds the input through 80 rounds at one per cycle and then the
// chaining add. The final word runs the padding one byte per cycle up to the
// length field, with one or two compressions on the way, then presents the
// five digest words word 0 first, after which the block is back at its
// initial state for the next message.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_has_byte  (i_has_byte),
        .i_is_last   (i_is_last),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word_index(o_word_index),
        .o_last_word (o_last_word)
    );

    sha1_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_byte     (i_message_byte),
        .o_status   (status),
        .o_head_word(o_digest_word)
    );

endmodule

### tb/sha1_message_digest_tb.sv
// self-checking testbench for the sha-1 digest block: random messages against a local digest model
`timescale 1ns / 1ps

module sha1_message_digest_tb;
    import sha1_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_last;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_message_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_is_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_message_digest dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_message_byte(i_message_byte), .i_has_byte(i_has_byte),
        .i_is_last(i_is_last), .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always #6 i_clk = ~i_clk;

    t_msg_item    pending_bytes[$];
    t_digest_word expected_digest[$];
    logic [31:0]  hash_state[5];
    logic [31:0]  block_buf[16];
    logic [60:0]  byte_count;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off = 0;
    bit           timed_out = 0;
    bit           in_taken = 0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic hash_reset();
        hash_state[0] = H0; hash_state[1] = H1; hash_state[2] = H2;
        hash_state[3] = H3; hash_state[4] = H4;
        foreach (block_buf[i]) block_buf[i] = '0;
        byte_count = '0;
    endtask

    task automatic compress();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        logic [31:0] sched[80];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) sched[r] = block_buf[r];
            else sched[r] = rol(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            w = sched[r];
            t = rol(a, 5) + f + e + k + w;
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] v);
        if (pos % 4 == 0) block_buf[pos / 4] = '0;
        block_buf[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    endtask

    task automatic digest_accept(input t_msg_item it);
        int pos;
        logic [63:0] bits;
        t_digest_word dw;
        if (it.has_byte) begin
            pos = int'(byte_count[5:0]);
            place_byte(pos, it.data);
            byte_count = byte_count + 61'd1;
            if (pos == 63) compress();
        end
        if (!it.is_last) return;
        pos = int'(byte_count[5:0]);
        place_byte(pos, PAD_BYTE);
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin place_byte(pos, 8'h00); pos++; end
            compress();
            pos = 0;
        end
        while (pos < 56) begin place_byte(pos, 8'h00); pos++; end
        bits = {byte_count, 3'b000};
        block_buf[14] = bits[63:32];
        block_buf[15] = bits[31:0];
        compress();
        for (int j = 0; j < 5; j++) begin
            dw.digest = hash_state[j];
            dw.index = 3'(j);
            dw.last = (j == 4);
            expected_digest.push_back(dw);
        end
        hash_reset();
    endtask

    task automatic add_message(input int len, input bit use_markers);
        t_msg_item it;
        for (int i = 0; i < len; i++) begin
            if (use_markers && $urandom_range(0, 9) == 0) begin
                it.data = 8'($urandom); it.has_byte = 0; it.is_last = 0;
                pending_bytes.push_back(it);
            end
            it.data = 8'($urandom); it.has_byte = 1;
            it.is_last = (i == len - 1) && $urandom_range(0, 1);
            pending_bytes.push_back(it);
            if (it.is_last) return;
        end
        it.data = 8'($urandom); it.has_byte = 0; it.is_last = 1;
        pending_bytes.push_back(it);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                {i_message_byte, i_has_byte, i_is_last} <= pending_bytes.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        in_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (i_valid && !o_stall)
                digest_accept('{i_message_byte, i_has_byte, i_is_last});
            if (o_valid && !i_stall) begin
                if (expected_digest.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h index %0d", o_digest_word, o_word_index);
                end else begin
                    exp_w = expected_digest.pop_front();
                    if (exp_w != {o_digest_word, o_word_index, o_last_word}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("expected %h/%0d/%b got %h/%0d/%b", exp_w.digest,
                                exp_w.index, exp_w.last, o_digest_word, o_word_index,
                                o_last_word);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out = 1;
            $display("sha1_message_digest: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (pending_bytes.size() > 0 || i_valid || expected_digest.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_msg_item it;
        int lens[4];
        lens = '{0, 55, 56, 64};
        hash_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: an empty message, markers, short messages, extreme bytes
        pending_bytes.push_back('{8'hFF, 1'b0, 1'b1});
        pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
        pending_bytes.push_back('{8'hFF, 1'b1, 1'b0});
        pending_bytes.push_back('{8'hAA, 1'b0, 1'b0});
        pending_bytes.push_back('{8'h55, 1'b1, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0, 1'b1});
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 70 : (ph == 2 ? 30 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 70 : (ph == 1 ? 30 : 0);
            if (ph == 1) begin send_idle_pct = 70; recv_stall_pct = 0; end
            if (ph == 2) begin send_idle_pct = 0; recv_stall_pct = 70; end
            if (ph == 3) begin send_idle_pct = 30; recv_stall_pct = 30; end
            if (ph == 0) hold_off = 400;
            add_message(lens[ph], 0);
            add_message($urandom_range(0, 40), 1);
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_digest.size() == 0)
            $display("sha1_message_digest: match");
        else
            $display("sha1_message_digest: mismatch");
        $finish;
    end
endmodule

### files.f
design/sha1_pkg.sv
design/sha1_datapath.sv
design/sha1_ctrl.sv
design/sha1_message_digest.sv
tb/sha1_message_digest_tb.sv
